// ----- rtl/core/extended_float_divider_unit_assert.svh -----
// Assertion macros used by the checker file.
`ifndef EXTENDED_FLOAT_DIVIDER_UNIT_ASSERT_SVH
`define EXTENDED_FLOAT_DIVIDER_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define EFD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define EFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- rtl/core/efd_pkg.sv -----
// Package: payload types, constants and queue record for the extended float divider.
`default_nettype none
package efd_pkg;
   localparam logic [15:0] SignBit = 16'h8000;
   localparam logic [14:0] ExpMask = 15'h7fff;
   localparam int ExpBias = 16383;
   localparam int QuotSteps = 64;
   localparam int StepBits = $clog2(QuotSteps);
   localparam int QueueDepth = 2;

   typedef struct packed {
      logic [15:0] dividend_sign_exponent;
      logic [63:0] dividend_mantissa;
      logic [15:0] divisor_sign_exponent;
      logic [63:0] divisor_mantissa;
   } req_type;

   typedef struct packed {
      logic [15:0] quotient_sign_exponent;
      logic [63:0] quotient_mantissa;
      logic        quotient_written;
      logic        zero_divide_flag;
      logic        underflow_flag;
      logic        denormal_flag;
      logic        overflow_flag;
   } rsp_type;

   // Classified operation passed from front to back.
   typedef struct packed {
      logic        special;   // result already complete
      rsp_type     early;     // result for special cases
      logic        sign;
      logic [17:0] exponent;  // signed, never negative unless special
      logic [63:0] numerator;
      logic [63:0] denominator;
   } op_type;
endpackage
`default_nettype wire

// ----- rtl/core/efd_front.sv -----
// Front end: accepts requests, classifies special cases, normalizes the divisor.
`default_nettype none
module efd_front import efd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         op_valid,
   input  wire logic    op_stall,
   output op_type       op_data
);
   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_NORM = 2'b10
   } fstate_type;

   fstate_type  state_ff, state_in;
   op_type      op_ff, op_in;
   logic        valid_ff, valid_in;
   logic        accept;
   logic        sign;
   logic [17:0] exp_diff;

   assign req_stall = (state_ff != F_IDLE) || valid_ff;
   assign accept    = req_valid && !req_stall;
   assign op_valid  = valid_ff;
   assign op_data   = op_ff;

   assign sign = req_data.dividend_sign_exponent[15] ^ req_data.divisor_sign_exponent[15];
   assign exp_diff = {3'b000, req_data.dividend_sign_exponent[14:0]}
                   - {3'b000, req_data.divisor_sign_exponent[14:0]} + 18'(ExpBias);

   // Classification on accept, then one-bit-a-cycle divisor normalization.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      valid_in = valid_ff;
      if (valid_ff && !op_stall) valid_in = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               op_in.sign        = sign;
               op_in.exponent    = exp_diff;
               op_in.numerator   = req_data.dividend_mantissa;
               op_in.denominator = req_data.divisor_mantissa;
               op_in.early       = '0;
               op_in.special     = 1'b0;
               if (req_data.divisor_mantissa == 64'd0) begin
                  op_in.special = 1'b1;
                  op_in.early.zero_divide_flag = 1'b1;
                  valid_in = 1'b1;
               end else if (exp_diff[17]) begin
                  op_in.special = 1'b1;
                  op_in.early.underflow_flag = 1'b1;
                  op_in.early.quotient_written = 1'b1;
                  op_in.early.quotient_sign_exponent = sign ? SignBit : 16'd0;
                  valid_in = 1'b1;
               end else if (req_data.divisor_mantissa[63]) begin
                  valid_in = 1'b1;
               end else begin
                  state_in = F_NORM;
               end
            end
         end
         F_NORM: begin
            op_in.denominator = {op_ff.denominator[62:0], 1'b0};
            op_in.exponent    = op_ff.exponent + 18'd1;
            if (op_ff.denominator[62]) begin
               state_in = F_IDLE;
               valid_in = 1'b1;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      op_ff <= op_in;
   end
endmodule
`default_nettype wire

// ----- rtl/core/efd_queue.sv -----
// Short FIFO between front and back end.
`default_nettype none
module efd_queue import efd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   output logic        in_stall,
   input  wire op_type in_data,
   output logic        out_valid,
   input  wire logic   out_stall,
   output op_type      out_data
);
   localparam int PtrBits = $clog2(QueueDepth);
   op_type              mem_ff [QueueDepth];
   logic [PtrBits-1:0]  wr_ff, rd_ff;
   logic [PtrBits:0]    count_ff;
   logic                push, pop;

   assign in_stall  = (count_ff == (PtrBits+1)'(QueueDepth));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule
`default_nettype wire

// ----- rtl/core/efd_back.sv -----
// Back end: restoring division, quotient normalization, result register.
`default_nettype none
module efd_back import efd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   op_valid,
   output logic        op_stall,
   input  wire op_type op_data,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output rsp_type     rsp_data
);
   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_DIV  = 4'b0010,
      B_NORM = 4'b0100,
      B_DONE = 4'b1000
   } bstate_type;

   bstate_type          state_ff, state_in;
   logic [127:0]        rem_ff, rem_in, dv_ff, dv_in;
   logic [63:0]         q_ff, q_in;
   logic [17:0]         e_ff, e_in;
   logic                sign_ff, sign_in;
   logic [StepBits-1:0] step_ff, step_in;
   rsp_type             out_ff, out_in;
   logic                oval_ff, oval_in;
   logic [128:0]        diff;

   // Accept while idle unless a waiting result is still stalled.
   assign op_stall  = (state_ff != B_IDLE) || (oval_ff && rsp_stall);
   assign rsp_valid = oval_ff;
   assign rsp_data  = out_ff;
   assign diff = {1'b0, rem_ff} - {1'b0, dv_ff};

   always_comb begin
      state_in = state_ff;
      rem_in = rem_ff; dv_in = dv_ff; q_in = q_ff; e_in = e_ff;
      sign_in = sign_ff; step_in = step_ff; out_in = out_ff; oval_in = oval_ff;
      if (oval_ff && !rsp_stall) oval_in = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (op_valid && !op_stall) begin
               if (op_data.special) begin
                  out_in = op_data.early;
                  oval_in = 1'b1;
               end else begin
                  rem_in = {op_data.numerator, 64'd0};
                  dv_in  = {op_data.denominator, 64'd0};
                  q_in = '0;
                  e_in = op_data.exponent;
                  sign_in = op_data.sign;
                  step_in = '0;
                  state_in = B_DIV;
               end
            end
         end
         // One quotient bit per cycle.
         B_DIV: begin
            if (!diff[128]) begin
               rem_in = diff[127:0];
               q_in[~step_ff] = 1'b1;
            end
            dv_in = {1'b0, dv_ff[127:1]};
            step_in = step_ff + 1'b1;
            if (step_ff == StepBits'(QuotSteps - 1)) state_in = B_NORM;
         end
         // One left shift per cycle until MSB set or exponent zero.
         B_NORM: begin
            if (q_ff == 64'd0) begin
               e_in = '0;
               state_in = B_DONE;
            end else if (e_ff != '0 && !q_ff[63]) begin
               e_in = e_ff - 18'd1;
               q_in = {q_ff[62:0], 1'b0};
            end else begin
               state_in = B_DONE;
            end
         end
         // Form the result once the output register is free.
         B_DONE: begin
            if (!oval_ff || !rsp_stall) begin
               out_in = '0;
               if (e_ff > {3'b000, ExpMask}) begin
                  out_in.overflow_flag = 1'b1;
               end else begin
                  out_in.quotient_sign_exponent = {sign_ff, e_ff[14:0]};
                  out_in.quotient_mantissa = q_ff;
                  out_in.quotient_written = 1'b1;
                  out_in.denormal_flag = (q_ff != 64'd0) && !q_ff[63];
               end
               oval_in = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         oval_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         oval_ff <= oval_in;
      end
      rem_ff <= rem_in; dv_ff <= dv_in; q_ff <= q_in; e_ff <= e_in;
      sign_ff <= sign_in; step_ff <= step_in; out_ff <= out_in;
   end
endmodule
`default_nettype wire

// ----- rtl/core/extended_float_divider_unit.sv -----
// Top level of the 80-bit extended real divider.
// Usage:
//   req channel carries dividend and divisor (valid/stall, transfer when
//   valid high and stall low); rsp channel returns one result per request.
//   Front end classifies zero-divide and underflow at once and normalizes
//   the divisor one bit per cycle. A two-entry queue sits between front
//   and back. The back end runs a radix-2 restoring divider, one quotient
//   bit a cycle, then normalizes the quotient one shift a cycle and forms
//   the result once its output register is free. Each divisor or quotient
//   shift delays the response further. The back end takes a new item only
//   once it is idle again, with front-end work of the next item overlapping
//   it. Special cases return without the back-end divide.
//   Reset (synchronous, active high) empties the queue and all stages.
//   A stalled response holds its payload; the back end waits, the queue
//   fills, and then req_stall rises.
`default_nettype none
module extended_float_divider_unit import efd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   logic   f_valid, f_stall, b_valid, b_stall;
   op_type f_data, b_data;

   efd_front u_front (.clock, .reset, .req_valid, .req_stall, .req_data,
      .op_valid(f_valid), .op_stall(f_stall), .op_data(f_data));
   efd_queue u_queue (.clock, .reset, .in_valid(f_valid), .in_stall(f_stall),
      .in_data(f_data), .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data));
   efd_back u_back (.clock, .reset, .op_valid(b_valid), .op_stall(b_stall),
      .op_data(b_data), .rsp_valid, .rsp_stall, .rsp_data);
endmodule
`default_nettype wire

// ----- rtl/core/efd_checker.sv -----
// Port-level checker for the divider, bound to the top level.
`default_nettype none
`include "extended_float_divider_unit_assert.svh"
module efd_checker import efd_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);
   `EFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")
   `EFD_ASSERT_IMPL(a_zdiv_unwritten, clock, reset, rsp_valid && rsp_data.zero_divide_flag, !rsp_data.quotient_written, "zero-divide wrote a quotient")
   `EFD_ASSERT_IMPL(a_ovf_unwritten, clock, reset, rsp_valid && rsp_data.overflow_flag, !rsp_data.quotient_written && rsp_data.quotient_mantissa == 64'd0, "overflow wrote a quotient")
   `EFD_ASSERT_IMPL(a_one_flag, clock, reset, rsp_valid, $onehot0({rsp_data.zero_divide_flag, rsp_data.underflow_flag, rsp_data.overflow_flag, rsp_data.denormal_flag}), "conflicting flags")
endmodule

bind extended_float_divider_unit efd_checker u_checker (.clock, .reset, .rsp_valid,
   .rsp_stall, .rsp_data);
`default_nettype wire

// ----- tb/extended_float_divider_unit_test.sv -----
// Self-checking testbench for the extended float divider: directed and random operands.
`default_nettype none
module extended_float_divider_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import efd_pkg::*;

   localparam int IdleLimit = 20000;
   localparam int DrainCycles = 300;
   localparam int RandomItems = 1350;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;

   req_type pending_ops[$];
   rsp_type expected_quotients[$];
   int sender_idle_pct;
   int receiver_stall_pct;
   int mismatches;
   int idle_cycles;
   bit stimulus_done;
   bit req_taken;
   bit watchdog_expired;

   extended_float_divider_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Predicted quotient for one operand pair.
   function automatic rsp_type divide_extended(req_type op);
      rsp_type res;
      logic [15:0] sign;
      logic [63:0] num;
      logic [63:0] den;
      logic [127:0] rem;
      logic [127:0] dv;
      logic [63:0] quo;
      int expo;
      res = '0;
      sign = (op.dividend_sign_exponent ^ op.divisor_sign_exponent) & SignBit;
      num = op.dividend_mantissa;
      den = op.divisor_mantissa;
      if (den == 64'd0) begin
         res.zero_divide_flag = 1'b1;
         return res;
      end
      expo = int'(op.dividend_sign_exponent[14:0]) - int'(op.divisor_sign_exponent[14:0])
         + ExpBias;
      if (expo < 0) begin
         res.quotient_sign_exponent = sign;
         res.quotient_written = 1'b1;
         res.underflow_flag = 1'b1;
         return res;
      end
      while (!den[63]) begin
         den = den << 1;
         expo++;
      end
      // restoring divide, one quotient bit per step
      rem = {num, 64'd0};
      dv = {den, 64'd0};
      quo = '0;
      for (int k = 0; k < QuotSteps; k++) begin
         if (rem >= dv) begin
            rem = rem - dv;
            quo[63 - k] = 1'b1;
         end
         dv = dv >> 1;
      end
      if (quo != 64'd0) begin
         while (expo != 0 && !quo[63]) begin
            expo--;
            quo = quo << 1;
         end
         if (!quo[63]) res.denormal_flag = 1'b1;
      end else begin
         expo = 0;
      end
      if (expo > 32767) begin
         res.overflow_flag = 1'b1;
         return res;
      end
      res.quotient_sign_exponent = sign | 16'(expo);
      res.quotient_mantissa = quo;
      res.quotient_written = 1'b1;
      return res;
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   // Mostly normalized operands with nearby exponents; some raw noise.
   function automatic req_type random_operands();
      req_type op;
      int kind;
      kind = $urandom_range(0, 99);
      op.dividend_sign_exponent = 16'($urandom());
      op.divisor_sign_exponent = 16'($urandom());
      op.dividend_mantissa = random_word();
      op.divisor_mantissa = random_word();
      if (kind < 60) begin
         op.dividend_mantissa[63] = 1'b1;
         op.divisor_mantissa[63] = 1'b1;
         op.divisor_sign_exponent[14:0] = 15'(int'(op.dividend_sign_exponent[14:0])
            + $urandom_range(0, 64) - 32);
      end else if (kind < 70) begin
         // short divisor: long normalization
         op.divisor_mantissa = op.divisor_mantissa >> $urandom_range(1, 63);
      end else if (kind < 78) begin
         op.dividend_mantissa = op.dividend_mantissa >> $urandom_range(1, 64);
      end else if (kind < 84) begin
         // near the bottom of the exponent range: denormal and underflow
         op.dividend_sign_exponent[14:0] = 15'($urandom_range(0, 70));
         op.divisor_sign_exponent[14:0] = 15'(ExpBias + $urandom_range(0, 70));
      end else if (kind < 90) begin
         op.dividend_sign_exponent[14:0] = 15'h7fff - 15'($urandom_range(0, 3));
         op.divisor_sign_exponent[14:0] = 15'(ExpBias - $urandom_range(0, 3));
         op.divisor_mantissa = op.divisor_mantissa >> $urandom_range(0, 8);
      end else if (kind < 93) begin
         op.divisor_mantissa = '0;
      end
      return op;
   endfunction

   function automatic req_type make_op(logic [15:0] se1, logic [63:0] m1,
                                       logic [15:0] se2, logic [63:0] m2);
      req_type op;
      op.dividend_sign_exponent = se1;
      op.dividend_mantissa = m1;
      op.divisor_sign_exponent = se2;
      op.divisor_mantissa = m2;
      return op;
   endfunction

   // Stimulus: directed corners then random phases with varying idling.
   initial begin
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      stimulus_done = 1'b0;
      pending_ops.push_back(make_op(16'h3fff, 64'h8000_0000_0000_0000,
                                    16'h3fff, 64'h8000_0000_0000_0000));
      pending_ops.push_back(make_op(16'hbfff, 64'hffff_ffff_ffff_ffff,
                                    16'h3fff, 64'h8000_0000_0000_0001));
      pending_ops.push_back(make_op(16'h4000, 64'hc000_0000_0000_0000,
                                    16'hc000, 64'ha000_0000_0000_0000));
      pending_ops.push_back(make_op(16'h1234, 64'h8000_0000_0000_0000, 16'hffff, '0));
      pending_ops.push_back(make_op(16'hffff, '1, 16'h0000, '0));
      pending_ops.push_back(make_op(16'h8000, 64'h8000_0000_0000_0000,
                                    16'h7fff, 64'h8000_0000_0000_0000));
      pending_ops.push_back(make_op(16'h0000, '1, 16'hffff, '1));
      pending_ops.push_back(make_op(16'h3fff, '0, 16'h3fff, 64'h8000_0000_0000_0000));
      pending_ops.push_back(make_op(16'hbfff, '0, 16'h0000, 64'd1));
      pending_ops.push_back(make_op(16'h0000, 64'h8000_0000_0000_0000,
                                    16'h3fff, 64'hffff_ffff_ffff_ffff));
      pending_ops.push_back(make_op(16'h0001, 64'd1, 16'h3fff, 64'h8000_0000_0000_0000));
      pending_ops.push_back(make_op(16'h7fff, '1, 16'h3fff, 64'h8000_0000_0000_0000));
      pending_ops.push_back(make_op(16'h7fff, '1, 16'h0000, 64'd1));
      pending_ops.push_back(make_op(16'h7fff, 64'h8000_0000_0000_0000,
                                    16'h3ffe, 64'hffff_ffff_ffff_ffff));
      pending_ops.push_back(make_op(16'h3fff, 64'd1, 16'h3fff, '1));
      pending_ops.push_back(make_op(16'hffff, '1, 16'h7fff, 64'd1));
      pending_ops.push_back(make_op(16'h5555, 64'haaaa_aaaa_aaaa_aaaa,
                                    16'h2aaa, 64'h5555_5555_5555_5555));
      pending_ops.push_back(make_op(16'h2aaa, 64'h5555_5555_5555_5555,
                                    16'hd555, 64'haaaa_aaaa_aaaa_aaaa));
      wait (!reset);
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 86; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 86; end
            3: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
            default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
         endcase
         for (int i = 0; i < RandomItems / 5; i++) pending_ops.push_back(random_operands());
         wait (pending_ops.size() == 0);
      end
      stimulus_done = 1'b1;
   end

   // Driver: inputs change on the falling edge; the driven item stays at the
   // queue head until its transfer.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
         if (!req_valid || req_taken) begin
            if (req_valid) void'(pending_ops.pop_front());
            if (pending_ops.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_ops[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predict on request transfer, check on response transfer.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (req_valid && !req_stall)
            expected_quotients.push_back(divide_extended(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_quotients.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               if (rsp_data !== expected_quotients[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p",
                              expected_quotients[0], rsp_data);
               end
               void'(expected_quotients.pop_front());
            end
         end
      end
   end

   // Reset, end of run and watchdog.
   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            wait (stimulus_done && expected_quotients.size() == 0);
            repeat (DrainCycles) @(posedge clock);
         end
         begin
            wait (idle_cycles >= IdleLimit);
            watchdog_expired = 1'b1;
            $display("watchdog: no transfer for %0d cycles", IdleLimit);
         end
      join_any
      if (mismatches == 0 && !watchdog_expired && expected_quotients.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (expected_quotients.size() != 0)
            $display("%0d responses missing", expected_quotients.size());
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
